// ----- rtl/core/kavt_pkg.sv -----
// Shared types, constants, arithmetic helpers and the update program of the angle tracker.
package kavt_pkg;

	localparam int FRAC_BITS = 48;
	localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
	localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

	localparam int RAM_DEPTH = 64;
	localparam int NUM_VLD = 12;
	localparam int PROG_LEN = 82;

	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
	localparam logic [2:0] REG_MEAS_NOISE = 3'd1;
	localparam logic [2:0] REG_Q_ANGLE = 3'd2;
	localparam logic [2:0] REG_Q_VELOCITY = 3'd3;
	localparam logic [2:0] REG_Q_ACCEL = 3'd4;
	localparam logic [2:0] REG_Q_ANGLE_VEL = 3'd5;
	localparam logic [2:0] REG_Q_ANGLE_ACC = 3'd6;
	localparam logic [2:0] REG_Q_VEL_ACC = 3'd7;

	localparam logic [1:0] OP_MAC = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_DIV = 2'd2;

	// operand codes: below 64 a memory address, else a fixed source
	localparam logic [6:0] SRC_ONE = 7'h40;
	localparam logic [6:0] SRC_ZERO = 7'h41;
	localparam logic [6:0] SRC_DT = 7'h42;
	localparam logic [6:0] SRC_R = 7'h43;
	localparam logic [6:0] SRC_Z = 7'h44;
	localparam logic [6:0] SRC_Q00 = 7'h45;
	localparam logic [6:0] SRC_Q11 = 7'h46;
	localparam logic [6:0] SRC_Q22 = 7'h47;
	localparam logic [6:0] SRC_Q01 = 7'h48;
	localparam logic [6:0] SRC_Q02 = 7'h49;
	localparam logic [6:0] SRC_Q12 = 7'h4A;

	localparam int ADR_X = 0;
	localparam int ADR_P = 3;
	localparam int ADR_T = 12;
	localparam int ADR_PP = 21;
	localparam int ADR_XP = 30;
	localparam int ADR_H = 33;
	localparam int ADR_Y = 34;
	localparam int ADR_S = 35;
	localparam int ADR_K = 36;
	localparam int ADR_M = 39;

	typedef struct packed {
		logic [1:0] op;
		logic first;
		logic last;
		logic sh;
		logic [5:0] dst;
		logic [6:0] a;
		logic [6:0] b;
	} uop_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] r;
		r = a + b;
		if (!a[63] && !b[63] && r[63]) r = SMAX;
		else if (a[63] && b[63] && !r[63]) r = SMIN;
		return r;
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] r;
		r = a - b;
		if (!a[63] && b[63] && r[63]) r = SMAX;
		else if (a[63] && !b[63] && !r[63]) r = SMIN;
		return r;
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] from_mag(input logic neg, input logic [127:0] m);
		logic [63:0] lim;
		logic [63:0] lo;
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		lo = ((m[127:64] != 64'd0) || (m[63:0] > lim)) ? lim : m[63:0];
		return neg ? $signed(-lo) : $signed(lo);
	endfunction

	function automatic uop_t mk(input logic [1:0] op, input logic first, input logic last,
			input logic sh, input logic [6:0] dst, input logic [6:0] a, input logic [6:0] b);
		uop_t u;
		u.op = op;
		u.first = first;
		u.last = last;
		u.sh = sh;
		u.dst = dst[5:0];
		u.a = a;
		u.b = b;
		return u;
	endfunction

	function automatic logic [6:0] adr(input int base, input int i, input int j);
		return 7'(base + 3 * i + j);
	endfunction

	// entry (i,k) of the transition matrix
	function automatic logic [6:0] a_code(input int i, input int k);
		logic [6:0] c;
		c = SRC_ZERO;
		if (i == k) c = SRC_ONE;
		else if (k == i + 1) c = SRC_DT;
		else if (k == i + 2) c = 7'(ADR_H);
		return c;
	endfunction

	function automatic logic [6:0] q_code(input int i, input int j);
		logic [6:0] c;
		c = SRC_Q00;
		if (i == 1 && j == 1) c = SRC_Q11;
		else if (i == 2 && j == 2) c = SRC_Q22;
		else if ((i == 0 && j == 1) || (i == 1 && j == 0)) c = SRC_Q01;
		else if ((i == 0 && j == 2) || (i == 2 && j == 0)) c = SRC_Q02;
		else if ((i == 1 && j == 2) || (i == 2 && j == 1)) c = SRC_Q12;
		return c;
	endfunction

	function automatic uop_t prog(input logic [6:0] pc);
		uop_t tbl [PROG_LEN];
		int n;
		uop_t r;
		n = 0;
		tbl[n] = mk(OP_MAC, 1'b1, 1'b1, 1'b1, 7'(ADR_H), SRC_DT, SRC_DT);
		n++;
		for (int i = 0; i < 3; i++) begin
			for (int c = i; c < 3; c++) begin
				tbl[n] = mk(OP_MAC, c == i, c == 2, 1'b0, 7'(ADR_XP + i), a_code(i, c),
					adr(ADR_X, 0, c));
				n++;
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = i; k < 3; k++) begin
					tbl[n] = mk(OP_MAC, k == i, k == 2, 1'b0, adr(ADR_T, i, j), a_code(i, k),
						adr(ADR_P, k, j));
					n++;
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = j; k < 3; k++) begin
					tbl[n] = mk(OP_MAC, k == j, 1'b0, 1'b0, adr(ADR_PP, i, j), adr(ADR_T, i, k),
						a_code(j, k));
					n++;
				end
				tbl[n] = mk(OP_MAC, 1'b0, 1'b1, 1'b0, adr(ADR_PP, i, j), q_code(i, j), SRC_ONE);
				n++;
			end
		end
		tbl[n] = mk(OP_SUB, 1'b1, 1'b1, 1'b0, 7'(ADR_Y), SRC_Z, 7'(ADR_XP));
		n++;
		tbl[n] = mk(OP_MAC, 1'b1, 1'b0, 1'b0, 7'(ADR_S), adr(ADR_PP, 0, 0), SRC_ONE);
		n++;
		tbl[n] = mk(OP_MAC, 1'b0, 1'b1, 1'b0, 7'(ADR_S), SRC_R, SRC_ONE);
		n++;
		for (int i = 0; i < 3; i++) begin
			tbl[n] = mk(OP_DIV, 1'b1, 1'b1, 1'b0, 7'(ADR_K + i), adr(ADR_PP, i, 0), 7'(ADR_S));
			n++;
		end
		for (int i = 0; i < 3; i++) begin
			tbl[n] = mk(OP_SUB, 1'b1, 1'b1, 1'b0, 7'(ADR_M + i), (i == 0) ? SRC_ONE : SRC_ZERO,
				7'(ADR_K + i));
			n++;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				tbl[n] = mk(OP_MAC, 1'b1, i == 0, 1'b0, adr(ADR_P, i, j), 7'(ADR_M + i),
					adr(ADR_PP, 0, j));
				n++;
				if (i != 0) begin
					tbl[n] = mk(OP_MAC, 1'b0, 1'b1, 1'b0, adr(ADR_P, i, j), SRC_ONE,
						adr(ADR_PP, i, j));
					n++;
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			tbl[n] = mk(OP_MAC, 1'b1, 1'b0, 1'b0, 7'(ADR_X + i), 7'(ADR_XP + i), SRC_ONE);
			n++;
			tbl[n] = mk(OP_MAC, 1'b0, 1'b1, 1'b0, 7'(ADR_X + i), 7'(ADR_K + i), 7'(ADR_Y));
			n++;
		end
		r = tbl[0];
		if (int'(pc) < PROG_LEN) r = tbl[pc];
		return r;
	endfunction

endpackage

// ----- rtl/core/kalman_angle_velocity_tracker.sv -----
// Top level of the three-state angle/velocity/acceleration Kalman tracker.
//
// Usage: one measured angle (signed Q16.48) enters on the in channel
// (in_valid/in_ready); one request on the out channel carries the updated
// angle, velocity and acceleration estimates. Filter constants sit in an
// APB-style register bank, 8 bytes per register, pready tied high; write
// them only while no sample is in flight.
// The state vector, covariance and all temporaries live in a 64-entry RAM
// (kept twice so two operands read per cycle). A sequencer walks an
// 82-step program: a multiply-accumulate passes the read, operand and
// MUL1-MUL3 states, a subtract read, operand and subtract, and each of
// the three gain divisions read, operand, setup, the divide loop (one
// quotient bit per cycle over 128 bits; skipped when the innovation
// variance is 0) and a final write. in_ready is high only in the idle
// state, so no new sample is taken before the last one has finished.
// Reset clears the state and covariance at once through per-entry valid
// bits (no clearing pass) and loads the register defaults. A stalled
// receiver holds the result register; a finished next sample waits in the
// done state until the register frees.
module kalman_angle_velocity_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [63:0] measured_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] angle_est,
	output logic signed [63:0] velocity_est,
	output logic signed [63:0] accel_est
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_READ = 4'd1;
	localparam logic [3:0] ST_OPND = 4'd2;
	localparam logic [3:0] ST_MUL1 = 4'd3;
	localparam logic [3:0] ST_MUL2 = 4'd4;
	localparam logic [3:0] ST_MUL3 = 4'd5;
	localparam logic [3:0] ST_SUB = 4'd6;
	localparam logic [3:0] ST_DIVI = 4'd7;
	localparam logic [3:0] ST_DIV = 4'd8;
	localparam logic [3:0] ST_DIVF = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	localparam int AW = $clog2(kavt_pkg::RAM_DEPTH);

	logic [48:0] sample_period_q;
	logic [62:0] meas_noise_q, q_angle_q, q_velocity_q, q_accel_q;
	logic [62:0] q_angle_vel_q, q_angle_acc_q, q_vel_acc_q;
	logic        cfg_we;

	logic [3:0]  state_q;
	logic [6:0]  pc_q;
	kavt_pkg::uop_t cur;
	logic signed [63:0] z_q, acc_q, opa_q, opb_q;
	logic [kavt_pkg::NUM_VLD-1:0] vld_q;
	logic [63:0] rd_a, rd_b;
	logic signed [63:0] src_a, src_b;
	logic        vld_a, vld_b;

	logic [63:0]  mag_a, mag_b;
	logic [63:0]  pp00_s1, pp01_s1, pp10_s1, pp11_s1;
	logic         neg_s1, neg_s2;
	logic [127:0] prod_s2, rnd, shv;
	logic signed [63:0] mres, mac_sum;

	logic [63:0]  rem_q, dv_q;
	logic [127:0] nq_q;
	logic [6:0]   div_cnt_q;
	logic         dneg_q, dzero_q;
	logic [64:0]  div_rs;
	logic         div_ge;

	logic         wb_en, ram_we;
	logic signed [63:0] wb_val;
	logic signed [63:0] res0_q, res1_q, res2_q;
	logic         out_valid_q;

	// configuration
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= 49'd2814749767107;
			meas_noise_q <= 63'd270724602925;
			q_angle_q <= 63'd78;
			q_velocity_q <= 63'd7036874;
			q_accel_q <= 63'd281474976711;
			q_angle_vel_q <= 63'd23456;
			q_angle_acc_q <= 63'd4691250;
			q_vel_acc_q <= 63'd1407374884;
		end else if (cfg_we) begin
			unique case (paddr[5:3])
				kavt_pkg::REG_SAMPLE_PERIOD: sample_period_q <= pwdata[48:0];
				kavt_pkg::REG_MEAS_NOISE: meas_noise_q <= pwdata[62:0];
				kavt_pkg::REG_Q_ANGLE: q_angle_q <= pwdata[62:0];
				kavt_pkg::REG_Q_VELOCITY: q_velocity_q <= pwdata[62:0];
				kavt_pkg::REG_Q_ACCEL: q_accel_q <= pwdata[62:0];
				kavt_pkg::REG_Q_ANGLE_VEL: q_angle_vel_q <= pwdata[62:0];
				kavt_pkg::REG_Q_ANGLE_ACC: q_angle_acc_q <= pwdata[62:0];
				kavt_pkg::REG_Q_VEL_ACC: q_vel_acc_q <= pwdata[62:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			kavt_pkg::REG_SAMPLE_PERIOD: prdata = 64'(sample_period_q);
			kavt_pkg::REG_MEAS_NOISE: prdata = 64'(meas_noise_q);
			kavt_pkg::REG_Q_ANGLE: prdata = 64'(q_angle_q);
			kavt_pkg::REG_Q_VELOCITY: prdata = 64'(q_velocity_q);
			kavt_pkg::REG_Q_ACCEL: prdata = 64'(q_accel_q);
			kavt_pkg::REG_Q_ANGLE_VEL: prdata = 64'(q_angle_vel_q);
			kavt_pkg::REG_Q_ANGLE_ACC: prdata = 64'(q_angle_acc_q);
			kavt_pkg::REG_Q_VEL_ACC: prdata = 64'(q_vel_acc_q);
			default: prdata = 64'd0;
		endcase
	end

	// program and operand fetch
	assign cur = kavt_pkg::prog(pc_q);

	kavt_ram #(.WIDTH(64), .DEPTH(kavt_pkg::RAM_DEPTH)) u_ram_a (
		.clk(clk), .we(ram_we), .waddr(cur.dst[AW-1:0]), .wdata(wb_val),
		.raddr(cur.a[AW-1:0]), .rdata(rd_a)
	);

	kavt_ram #(.WIDTH(64), .DEPTH(kavt_pkg::RAM_DEPTH)) u_ram_b (
		.clk(clk), .we(ram_we), .waddr(cur.dst[AW-1:0]), .wdata(wb_val),
		.raddr(cur.b[AW-1:0]), .rdata(rd_b)
	);

	function automatic logic [63:0] spec_val(input logic [6:0] code, input logic [63:0] dt,
			input logic [63:0] r, input logic [63:0] z, input logic [63:0] q00,
			input logic [63:0] q11, input logic [63:0] q22, input logic [63:0] q01,
			input logic [63:0] q02, input logic [63:0] q12);
		logic [63:0] v;
		unique case (code)
			kavt_pkg::SRC_ONE: v = kavt_pkg::ONE;
			kavt_pkg::SRC_DT: v = dt;
			kavt_pkg::SRC_R: v = r;
			kavt_pkg::SRC_Z: v = z;
			kavt_pkg::SRC_Q00: v = q00;
			kavt_pkg::SRC_Q11: v = q11;
			kavt_pkg::SRC_Q22: v = q22;
			kavt_pkg::SRC_Q01: v = q01;
			kavt_pkg::SRC_Q02: v = q02;
			kavt_pkg::SRC_Q12: v = q12;
			default: v = 64'd0;
		endcase
		return v;
	endfunction

	assign vld_a = (cur.a[5:0] < 6'(kavt_pkg::NUM_VLD)) ? vld_q[cur.a[3:0]] : 1'b1;
	assign vld_b = (cur.b[5:0] < 6'(kavt_pkg::NUM_VLD)) ? vld_q[cur.b[3:0]] : 1'b1;

	assign src_a = cur.a[6] ? $signed(spec_val(cur.a, 64'(sample_period_q), 64'(meas_noise_q),
		z_q, 64'(q_angle_q), 64'(q_velocity_q), 64'(q_accel_q), 64'(q_angle_vel_q),
		64'(q_angle_acc_q), 64'(q_vel_acc_q))) : (vld_a ? $signed(rd_a) : 64'sd0);
	assign src_b = cur.b[6] ? $signed(spec_val(cur.b, 64'(sample_period_q), 64'(meas_noise_q),
		z_q, 64'(q_angle_q), 64'(q_velocity_q), 64'(q_accel_q), 64'(q_angle_vel_q),
		64'(q_angle_acc_q), 64'(q_vel_acc_q))) : (vld_b ? $signed(rd_b) : 64'sd0);

	// multiplier path
	assign mag_a = kavt_pkg::mag(opa_q);
	assign mag_b = kavt_pkg::mag(opb_q);
	assign rnd = cur.sh ? (128'd1 << kavt_pkg::FRAC_BITS)
		: (128'd1 << (kavt_pkg::FRAC_BITS - 1));
	assign shv = cur.sh ? (prod_s2 >> (kavt_pkg::FRAC_BITS + 1))
		: (prod_s2 >> kavt_pkg::FRAC_BITS);
	assign mres = kavt_pkg::from_mag(neg_s2, shv);
	assign mac_sum = kavt_pkg::sat_add(cur.first ? 64'sd0 : acc_q, mres);

	always_ff @(posedge clk) begin
		pp00_s1 <= {32'd0, mag_a[31:0]} * {32'd0, mag_b[31:0]};
		pp01_s1 <= {32'd0, mag_a[31:0]} * {32'd0, mag_b[63:32]};
		pp10_s1 <= {32'd0, mag_a[63:32]} * {32'd0, mag_b[31:0]};
		pp11_s1 <= {32'd0, mag_a[63:32]} * {32'd0, mag_b[63:32]};
		neg_s1 <= opa_q[63] ^ opb_q[63];
		prod_s2 <= {64'd0, pp00_s1} + ({64'd0, pp01_s1} << 32) + ({64'd0, pp10_s1} << 32)
			+ {pp11_s1, 64'd0} + rnd;
		neg_s2 <= neg_s1;
	end

	// divider step
	assign div_rs = {rem_q, nq_q[127]};
	assign div_ge = div_rs >= {1'b0, dv_q};

	// writeback
	always_comb begin
		wb_en = 1'b0;
		wb_val = 64'sd0;
		unique case (state_q)
			ST_MUL3: begin
				wb_en = 1'b1;
				wb_val = mac_sum;
			end
			ST_SUB: begin
				wb_en = 1'b1;
				wb_val = kavt_pkg::sat_sub(opa_q, opb_q);
			end
			ST_DIVF: begin
				wb_en = 1'b1;
				wb_val = dzero_q ? 64'sd0 : kavt_pkg::from_mag(dneg_q, nq_q);
			end
			default: ;
		endcase
	end

	assign ram_we = wb_en & cur.last;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_OPND: begin
				opa_q <= src_a;
				opb_q <= src_b;
			end
			ST_DIVI: begin
				nq_q <= 128'(mag_a) << kavt_pkg::FRAC_BITS;
				dv_q <= mag_b;
				rem_q <= 64'd0;
				dneg_q <= opa_q[63] ^ opb_q[63];
				dzero_q <= (opb_q == 64'sd0);
			end
			ST_DIV: begin
				rem_q <= div_ge ? 64'(div_rs - {1'b0, dv_q}) : div_rs[63:0];
				nq_q <= {nq_q[126:0], div_ge};
			end
			ST_MUL3: acc_q <= mac_sum;
			default: ;
		endcase
		if (in_valid && in_ready) z_q <= measured_angle;
		if (ram_we) begin
			if (cur.dst == 6'(kavt_pkg::ADR_X)) res0_q <= wb_val;
			if (cur.dst == 6'(kavt_pkg::ADR_X + 1)) res1_q <= wb_val;
			if (cur.dst == 6'(kavt_pkg::ADR_X + 2)) res2_q <= wb_val;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= 7'd0;
			div_cnt_q <= 7'd0;
			vld_q <= '0;
		end else begin
			if (ram_we && (cur.dst < 6'(kavt_pkg::NUM_VLD))) vld_q[cur.dst[3:0]] <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pc_q <= 7'd0;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_OPND;
				ST_OPND: begin
					unique case (cur.op)
						kavt_pkg::OP_MAC: state_q <= ST_MUL1;
						kavt_pkg::OP_SUB: state_q <= ST_SUB;
						kavt_pkg::OP_DIV: state_q <= ST_DIVI;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_DIVI: begin
					div_cnt_q <= 7'd0;
					state_q <= (opb_q == 64'sd0) ? ST_DIVF : ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 7'd1;
					if (div_cnt_q == 7'd127) state_q <= ST_DIVF;
				end
				ST_MUL3, ST_SUB, ST_DIVF: begin
					if (pc_q == 7'(kavt_pkg::PROG_LEN - 1)) begin
						state_q <= ST_DONE;
					end else begin
						pc_q <= pc_q + 7'd1;
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			angle_est <= res0_q;
			velocity_est <= res1_q;
			accel_est <= res2_q;
		end
	end

	assign out_valid = out_valid_q;

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !out_ready) |=> (state_q == ST_DONE))
		else $error("result overwritten while receiver stalls");

	a_start_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_READ && pc_q == 7'd0))
		else $error("sample did not start at program entry");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_MUL3 || state_q == ST_SUB || state_q == ST_DIVF))
		else $error("memory write outside writeback");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q != 7'd127) |=> (state_q == ST_DIV))
		else $error("division left early");

endmodule

// ----- rtl/core/kavt_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module kavt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ----- tb/kalman_angle_velocity_tracker_tb.sv -----
// Self-checking testbench for the angle tracker: bit-exact filter prediction, random handshakes.
`timescale 1ns / 1ps
module kalman_angle_velocity_tracker_tb;

	typedef logic signed [63:0] fix_t;
	typedef fix_t mat_t [3][3];
	typedef struct packed {
		fix_t angle;
		fix_t velocity;
		fix_t accel;
	} est_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	fix_t measured_angle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	fix_t angle_est, velocity_est, accel_est;

	kalman_angle_velocity_tracker u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .measured_angle(measured_angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.angle_est(angle_est), .velocity_est(velocity_est), .accel_est(accel_est)
	);

	always #2 clk = ~clk;

	// filter constants and state as the block should hold them
	logic [63:0] cfg_reg [8];
	fix_t trk_x [3];
	fix_t trk_p [3][3];

	fix_t angle_queue [$];
	est_t estimate_queue [$];
	logic calm = 1'b0;
	int n_samples = 0;
	int n_estimates = 0;
	int n_errors = 0;
	int n_zero_gain = 0;
	int n_phases = 0;

	function automatic logic [63:0] magn(input fix_t v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic fix_t clamp(input logic neg, input logic [127:0] m);
		logic [63:0] lim;
		logic [63:0] lo;
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		lo = (m > {64'd0, lim}) ? lim : m[63:0];
		return neg ? fix_t'(-lo) : fix_t'(lo);
	endfunction

	function automatic fix_t qadd(input fix_t a, input fix_t b);
		fix_t r;
		r = a + b;
		if (!a[63] && !b[63] && r[63]) r = kavt_pkg::SMAX;
		else if (a[63] && b[63] && !r[63]) r = kavt_pkg::SMIN;
		return r;
	endfunction

	function automatic fix_t qsub(input fix_t a, input fix_t b);
		fix_t r;
		r = a - b;
		if (!a[63] && b[63] && r[63]) r = kavt_pkg::SMAX;
		else if (a[63] && !b[63] && !r[63]) r = kavt_pkg::SMIN;
		return r;
	endfunction

	function automatic fix_t qmul(input fix_t a, input fix_t b, input int sh);
		logic [127:0] m;
		m = {64'd0, magn(a)} * {64'd0, magn(b)};
		m = (m + (128'd1 << (sh - 1))) >> sh;
		return clamp(a[63] ^ b[63], m);
	endfunction

	function automatic fix_t qdiv(input fix_t n, input fix_t d);
		logic [127:0] m;
		m = ({64'd0, magn(n)} << kavt_pkg::FRAC_BITS) / {64'd0, magn(d)};
		return clamp(n[63] ^ d[63], m);
	endfunction

	function automatic mat_t matmul(input mat_t a, input mat_t b);
		mat_t r;
		fix_t acc;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = '0;
				for (int k = 0; k < 3; k++)
					acc = qadd(acc, qmul(a[i][k], b[k][j], kavt_pkg::FRAC_BITS));
				r[i][j] = acc;
			end
		return r;
	endfunction

	function automatic est_t track_sample(input fix_t z);
		mat_t a, at, pp, m;
		fix_t xp [3];
		fix_t gain [3];
		fix_t dt, h, y, s, acc, one;
		est_t e;
		one = fix_t'(kavt_pkg::ONE);
		dt = fix_t'(cfg_reg[kavt_pkg::REG_SAMPLE_PERIOD]);
		h = qmul(dt, dt, kavt_pkg::FRAC_BITS + 1);
		a = '{'{one, dt, h}, '{0, one, dt}, '{0, 0, one}};
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) at[i][j] = a[j][i];
		for (int i = 0; i < 3; i++) begin
			acc = '0;
			for (int c = 0; c < 3; c++)
				acc = qadd(acc, qmul(a[i][c], trk_x[c], kavt_pkg::FRAC_BITS));
			xp[i] = acc;
		end
		pp = matmul(matmul(a, trk_p), at);
		pp[0][0] = qadd(pp[0][0], fix_t'(cfg_reg[kavt_pkg::REG_Q_ANGLE]));
		pp[1][1] = qadd(pp[1][1], fix_t'(cfg_reg[kavt_pkg::REG_Q_VELOCITY]));
		pp[2][2] = qadd(pp[2][2], fix_t'(cfg_reg[kavt_pkg::REG_Q_ACCEL]));
		pp[0][1] = qadd(pp[0][1], fix_t'(cfg_reg[kavt_pkg::REG_Q_ANGLE_VEL]));
		pp[1][0] = qadd(pp[1][0], fix_t'(cfg_reg[kavt_pkg::REG_Q_ANGLE_VEL]));
		pp[0][2] = qadd(pp[0][2], fix_t'(cfg_reg[kavt_pkg::REG_Q_ANGLE_ACC]));
		pp[2][0] = qadd(pp[2][0], fix_t'(cfg_reg[kavt_pkg::REG_Q_ANGLE_ACC]));
		pp[1][2] = qadd(pp[1][2], fix_t'(cfg_reg[kavt_pkg::REG_Q_VEL_ACC]));
		pp[2][1] = qadd(pp[2][1], fix_t'(cfg_reg[kavt_pkg::REG_Q_VEL_ACC]));
		y = qsub(z, xp[0]);
		s = qadd(pp[0][0], fix_t'(cfg_reg[kavt_pkg::REG_MEAS_NOISE]));
		if (s == 0) n_zero_gain++;
		for (int i = 0; i < 3; i++) begin
			gain[i] = (s == 0) ? fix_t'(0) : qdiv(pp[i][0], s);
			trk_x[i] = qadd(xp[i], qmul(gain[i], y, kavt_pkg::FRAC_BITS));
			for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? one : fix_t'(0);
			m[i][0] = qsub(m[i][0], gain[i]);
		end
		trk_p = matmul(m, pp);
		e.angle = trk_x[0];
		e.velocity = trk_x[1];
		e.accel = trk_x[2];
		return e;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (angle_queue.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
				in_valid <= 1'b1;
				measured_angle <= angle_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// accepted samples feed the prediction; results are checked in order
	always @(posedge clk or negedge arst_n) begin
		est_t exp_e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 30);
			if (in_valid && in_ready) begin
				estimate_queue.push_back(track_sample(measured_angle));
				n_samples++;
			end
			if (out_valid && out_ready) begin
				n_estimates++;
				if (estimate_queue.size() == 0) begin
					$error("unexpected estimate angle=%0d", angle_est);
					n_errors++;
				end else begin
					exp_e = estimate_queue.pop_front();
					if (angle_est !== exp_e.angle) begin
						$error("angle_est expected %0d got %0d", exp_e.angle, angle_est);
						n_errors++;
					end
					if (velocity_est !== exp_e.velocity) begin
						$error("velocity_est expected %0d got %0d", exp_e.velocity, velocity_est);
						n_errors++;
					end
					if (accel_est !== exp_e.accel) begin
						$error("accel_est expected %0d got %0d", exp_e.accel, accel_est);
						n_errors++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("timeout: %0d requests pending, %0d estimates owed",
				angle_queue.size(), estimate_queue.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_reg[idx] = (idx == kavt_pkg::REG_SAMPLE_PERIOD) ? (val & 64'h1_FFFF_FFFF_FFFF) :
			(val & 64'h7FFF_FFFF_FFFF_FFFF);
	endtask

	task automatic drain();
		wait (angle_queue.size() == 0 && !in_valid && estimate_queue.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_all(input logic [63:0] dt, input logic [63:0] r, input logic [63:0] qd,
			input logic [63:0] qo);
		write_reg(kavt_pkg::REG_SAMPLE_PERIOD, dt);
		write_reg(kavt_pkg::REG_MEAS_NOISE, r);
		write_reg(kavt_pkg::REG_Q_ANGLE, qd);
		write_reg(kavt_pkg::REG_Q_VELOCITY, qd ^ {$urandom, $urandom} & 64'hFFFF);
		write_reg(kavt_pkg::REG_Q_ACCEL, qd);
		write_reg(kavt_pkg::REG_Q_ANGLE_VEL, qo);
		write_reg(kavt_pkg::REG_Q_ANGLE_ACC, qo);
		write_reg(kavt_pkg::REG_Q_VEL_ACC, qo ^ {$urandom, $urandom} & 64'hFFFF);
	endtask

	// mostly noisy trajectories, some raw random words
	task automatic fill_random(input int n);
		fix_t pos, step, noise;
		pos = fix_t'({$urandom, $urandom}) >>> $urandom_range(16, 1);
		step = fix_t'({$urandom, $urandom}) >>> $urandom_range(40, 12);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 15) begin
				angle_queue.push_back(fix_t'({$urandom, $urandom}));
			end else begin
				noise = fix_t'({$urandom, $urandom}) >>> $urandom_range(60, 20);
				pos = qadd(pos, step);
				angle_queue.push_back(qadd(pos, noise));
			end
		end
	endtask

	initial begin
		fix_t seed_angles [$];
		cfg_reg[kavt_pkg::REG_SAMPLE_PERIOD] = 64'd2814749767107;
		cfg_reg[kavt_pkg::REG_MEAS_NOISE] = 64'd270724602925;
		cfg_reg[kavt_pkg::REG_Q_ANGLE] = 64'd78;
		cfg_reg[kavt_pkg::REG_Q_VELOCITY] = 64'd7036874;
		cfg_reg[kavt_pkg::REG_Q_ACCEL] = 64'd281474976711;
		cfg_reg[kavt_pkg::REG_Q_ANGLE_VEL] = 64'd23456;
		cfg_reg[kavt_pkg::REG_Q_ANGLE_ACC] = 64'd4691250;
		cfg_reg[kavt_pkg::REG_Q_VEL_ACC] = 64'd1407374884;
		for (int i = 0; i < 3; i++) begin
			trk_x[i] = '0;
			for (int j = 0; j < 3; j++) trk_p[i][j] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		seed_angles = '{0, kavt_pkg::SMAX, kavt_pkg::SMIN, 1, -1, 64'sh5555_5555_5555_5555,
			64'shAAAA_AAAA_AAAA_AAAA, fix_t'(kavt_pkg::ONE), -fix_t'(kavt_pkg::ONE), 0, 0,
			64'sh0000_0000_0001_0000};
		foreach (seed_angles[i]) angle_queue.push_back(seed_angles[i]);
		drain();

		// zero sample period, measurement noise and angle process noise
		set_all(64'd0, 64'd0, 64'd0, 64'd0);
		angle_queue.push_back(fix_t'(kavt_pkg::ONE));
		angle_queue.push_back(kavt_pkg::SMIN);
		angle_queue.push_back(kavt_pkg::SMAX);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			n_phases++;
			case (ph)
				0: set_all(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
					64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
				1: set_all(64'd2814749767107, 64'd270724602925, 64'd78, 64'd23456);
				2: set_all(64'h1_0000_0000_0000, 64'd1, 64'd0, 64'd0);
				3: set_all(64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 64'd0);
				default: set_all({$urandom, $urandom} >> $urandom_range(63, 14),
					{$urandom, $urandom} >> $urandom_range(63, 16),
					{$urandom, $urandom} >> $urandom_range(63, 20),
					{$urandom, $urandom} >> $urandom_range(63, 20));
			endcase
			calm = (ph == 5);
			fill_random(200);
			drain();
		end
		calm = 1'b0;
		repeat (900) @(posedge clk);
		$display("%0d samples over %0d register settings, %0d estimates checked",
			n_samples, n_phases + 2, n_estimates);
		$display("%0d samples ran with zero gain, %0d mismatches", n_zero_gain, n_errors);
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
